// ----- src/imu_serial_frame_parser_core_macros.svh -----
// Assertion macros for the IMU serial frame parser.
// Included by the top level; the enclosing module must provide clk and rst.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/isfp_pkg.sv -----
// Shared types, constants and the CRC-16 byte step for the IMU frame parser.
// No dependencies; every file but isfp_if.sv and the macro header imports this package.
package isfp_pkg;

  localparam int DataLength = 76;
  localparam int NumWords   = 19;
  localparam int WordIdxW   = 5;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_UNSUP   = 2'd3;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_DATA_TAG    = 2'd2;
  localparam logic [1:0] CFG_CRC_ENABLE  = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic                we;
    logic [1:0]          index;
    logic [7:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic                en;
    logic [WordIdxW-1:0] word;
    logic [1:0]          lane;
    logic [7:0]          data;
  } store_wr_t;

  typedef struct packed {
    logic                push;
    logic [1:0]          status;
  } job_push_t;

  typedef struct packed {
    logic                good_done;
  } back_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/isfp_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on nothing; used by the top level and its submodules.
interface isfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface isfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  word_index;
  logic [31:0] word_value;
  logic        last;
  modport source (output valid, output status, output word_index, output word_value,
                  output last, input ready);
  modport sink (input valid, input status, input word_index, input word_value,
                input last, output ready);
endinterface

// ----- src/isfp_front.sv -----
// Front end: configuration registers, frame state machine, running CRC and payload writes.
// Depends on isfp_pkg and isfp_byte_if; pushes frame outcomes to the job queue.
module isfp_front
  import isfp_pkg::*;
#(
  parameter int MaxPayload = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_wr_t     cfg,
  isfp_byte_if.sink   rx,
  input  logic        queue_full,
  input  back_stat_t  bstat,
  output job_push_t   job,
  output store_wr_t   store_wr
);

  localparam logic [2:0] PH_SYNC0 = 3'd0;
  localparam logic [2:0] PH_SYNC1 = 3'd1;
  localparam logic [2:0] PH_LEN0  = 3'd2;
  localparam logic [2:0] PH_LEN1  = 3'd3;
  localparam logic [2:0] PH_CHK0  = 3'd4;
  localparam logic [2:0] PH_CHK1  = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  data_tag;
  logic        crc_en;
  logic [15:0] sync_part;
  logic [15:0] sync_crc;
  logic [1:0]  settle;

  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] expected_check, expected_check_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_check, running_check_next;
  logic [7:0]  first_byte;
  logic        good_hold;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_in;
  logic [15:0] count_inc;
  logic [15:0] full_len;
  job_push_t   job_c;

  assign b         = rx.rx_byte;
  assign rx.ready  = !queue_full && !good_hold && (settle == 2'd0);
  assign accept    = rx.valid && rx.ready;
  assign crc_in    = crc_byte((phase == PH_LEN0) ? sync_crc : running_check, b);
  assign count_inc = byte_count + 16'd1;
  assign full_len  = {b, frame_length[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'h5A;
      sync_second <= 8'hA5;
      data_tag    <= 8'h91;
      crc_en      <= 1'b0;
      settle      <= 2'd2;
    end else begin
      if (cfg.we) begin
        settle <= 2'd2;
        unique case (cfg.index)
          CFG_SYNC_FIRST:  sync_first  <= cfg.data;
          CFG_SYNC_SECOND: sync_second <= cfg.data;
          CFG_DATA_TAG:    data_tag    <= cfg.data;
          CFG_CRC_ENABLE:  crc_en      <= cfg.data[0];
          default:         ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  // The CRC seed over both sync bytes is pipelined through the registers sync_part and sync_crc.
  always_ff @(posedge clk) begin
    sync_part <= crc_byte(CRC_INIT, sync_first);
    sync_crc  <= crc_byte(sync_part, sync_second);
  end

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    expected_check_next = expected_check;
    byte_count_next     = byte_count;
    running_check_next  = running_check;
    job_c.push          = 1'b0;
    job_c.status        = ST_GOOD;
    unique case (phase)
      PH_SYNC1: begin
        if (b == sync_second) begin
          phase_next = PH_LEN0;
        end else if (b == sync_first) begin
          phase_next = PH_SYNC1;
        end else begin
          phase_next = PH_SYNC0;
        end
      end
      PH_LEN0: begin
        frame_length_next  = {8'h00, b};
        running_check_next = crc_in;
        phase_next         = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next  = full_len;
        running_check_next = crc_in;
        phase_next         = PH_CHK0;
        if (full_len == 16'd0 || full_len > 16'(MaxPayload)) begin
          job_c.push          = 1'b1;
          job_c.status        = ST_BAD_LEN;
          phase_next          = PH_SYNC0;
          frame_length_next   = 16'd0;
          expected_check_next = 16'd0;
          byte_count_next     = 16'd0;
          running_check_next  = CRC_INIT;
        end
      end
      PH_CHK0: begin
        expected_check_next = {8'h00, b};
        phase_next          = PH_CHK1;
      end
      PH_CHK1: begin
        expected_check_next = {b, expected_check[7:0]};
        byte_count_next     = 16'd0;
        phase_next          = PH_DATA;
      end
      PH_DATA: begin
        running_check_next = crc_in;
        byte_count_next    = count_inc;
        if (count_inc >= frame_length) begin
          job_c.push = 1'b1;
          if (crc_en && crc_in != expected_check) begin
            job_c.status = ST_CRC_ERR;
          end else if (frame_length < 16'(DataLength) || first_byte != data_tag) begin
            job_c.status = ST_UNSUP;
          end else begin
            job_c.status = ST_GOOD;
          end
          phase_next          = PH_SYNC0;
          frame_length_next   = 16'd0;
          expected_check_next = 16'd0;
          byte_count_next     = 16'd0;
          running_check_next  = CRC_INIT;
        end
      end
      default: begin
        phase_next = (b == sync_first) ? PH_SYNC1 : PH_SYNC0;
      end
    endcase
  end

  assign job.push   = accept && job_c.push;
  assign job.status = job_c.status;

  assign store_wr.en   = accept && (phase == PH_DATA) && (byte_count < 16'(DataLength));
  assign store_wr.word = byte_count[WordIdxW+1:2];
  assign store_wr.lane = byte_count[1:0];
  assign store_wr.data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC0;
      frame_length   <= 16'd0;
      expected_check <= 16'd0;
      byte_count     <= 16'd0;
      running_check  <= CRC_INIT;
      good_hold      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        frame_length   <= frame_length_next;
        expected_check <= expected_check_next;
        byte_count     <= byte_count_next;
        running_check  <= running_check_next;
      end
      if (job.push && job.status == ST_GOOD) begin
        good_hold <= 1'b1;
      end else if (bstat.good_done) begin
        good_hold <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && byte_count == 16'd0) begin
      first_byte <= b;
    end
  end

endmodule

// ----- src/isfp_job_queue.sv -----
// Two-entry queue of frame outcomes between the front and back ends.
// Depends on isfp_pkg for the push record.
module isfp_job_queue
  import isfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_push_t  job,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] head_status
);

  logic [1:0] entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full        = (count == 2'd2);
  assign empty       = (count == 2'd0);
  assign head_status = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (job.push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      if ((job.push && !full) && !(pop && !empty)) begin
        count <= count + 2'd1;
      end else if (!(job.push && !full) && (pop && !empty)) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.push && !full) begin
      entries[wr_ptr] <= job.status;
    end
  end

endmodule

// ----- src/isfp_back.sv -----
// Back end: payload word memory and the result sequencer with its output register.
// Depends on isfp_pkg and isfp_result_if; pops outcomes from the job queue.
module isfp_back
  import isfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  store_wr_t    store_wr,
  input  logic         q_empty,
  input  logic [1:0]   head_status,
  output logic         pop,
  output back_stat_t   bstat,
  isfp_result_if.source res
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [31:0]         mem [NumWords];
  logic [31:0]         rdata;
  logic [WordIdxW-1:0] rd_addr;
  logic [1:0]          bstate;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [WordIdxW-1:0] out_index;
  logic [31:0]         out_value;
  logic                out_last;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.word][{store_wr.lane, 3'b000} +: 8] <= store_wr.data;
    end
    rdata <= mem[rd_addr];
  end

  assign pop             = (bstate == B_IDLE) && !q_empty;
  assign bstat.good_done = (bstate == B_OUT) && res.ready && out_last &&
                           (out_status == ST_GOOD);

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.word_index = out_index;
  assign res.word_value = out_value;
  assign res.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (bstate)
        B_IDLE: begin
          if (!q_empty) begin
            if (head_status == ST_GOOD) begin
              rd_addr <= '0;
              bstate  <= B_READ;
            end else begin
              out_status <= head_status;
              out_index  <= '0;
              out_value  <= 32'd0;
              out_last   <= 1'b1;
              out_valid  <= 1'b1;
              bstate     <= B_OUT;
            end
          end
        end
        B_READ: begin
          bstate <= B_LOAD;
        end
        B_LOAD: begin
          out_status <= ST_GOOD;
          out_index  <= rd_addr;
          out_value  <= rdata;
          out_last   <= (rd_addr == WordIdxW'(NumWords - 1));
          out_valid  <= 1'b1;
          bstate     <= B_OUT;
        end
        B_OUT: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              bstate <= B_IDLE;
            end else begin
              rd_addr <= rd_addr + WordIdxW'(1);
              bstate  <= B_READ;
            end
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/imu_serial_frame_parser_core.sv -----
// Top level of the IMU serial frame parser: front end, outcome queue and back end.
// Depends on isfp_pkg, isfp_if.sv, isfp_front, isfp_job_queue and isfp_back.
//
// Usage: received bytes arrive one item per handshake on rx (valid/ready); results
// leave on res, one item per handshake. Registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Throughput: rx takes one byte per cycle while hunting and receiving a frame, as long as
// the queue has room. A byte write to the configuration holds rx ready low while the
// sync CRC seed is recomputed through its registers; rx ready is also held low after reset.
// Results: the outcome of a frame is written into the queue with its last byte; an error
// result is then loaded into the output register. A good frame gives 19 words, each read
// from the payload word memory through a registered read (states B_READ, B_LOAD) into the
// output register; the next word is read only after the previous one is taken. From the
// end of a good frame until its last word is taken, rx is not ready.
// Reset: the parser hunts for the first sync byte, the queue is empty and the
// registers take their default values.
// Stalls: while res is held, the output register keeps its item and the two-entry
// queue absorbs frame outcomes; rx stops when the queue is full.
module imu_serial_frame_parser_core
  import isfp_pkg::*;
#(
  parameter int MaxPayload = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  isfp_byte_if.sink     rx,
  isfp_result_if.source res
);

  `include "imu_serial_frame_parser_core_macros.svh"

  cfg_wr_t    cfg;
  job_push_t  job;
  store_wr_t  store_wr;
  back_stat_t bstat;
  logic       queue_full;
  logic       q_empty;
  logic       pop;
  logic [1:0] head_status;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  isfp_front #(.MaxPayload(MaxPayload)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx         (rx),
    .queue_full (queue_full),
    .bstat      (bstat),
    .job        (job),
    .store_wr   (store_wr)
  );

  isfp_job_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .full        (queue_full),
    .pop         (pop),
    .empty       (q_empty),
    .head_status (head_status)
  );

  isfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .store_wr    (store_wr),
    .q_empty     (q_empty),
    .head_status (head_status),
    .pop         (pop),
    .bstat       (bstat),
    .res         (res)
  );

  `ISFP_ASSERT_NOW(a_nonlast_is_good, res.valid && !res.last, res.status == ST_GOOD, "non-final result without good status")
  `ISFP_ASSERT_NOW(a_error_zero, res.valid && res.status != ST_GOOD, res.word_index == 5'd0 && res.word_value == 32'd0, "error result with nonzero index or value")
  `ISFP_ASSERT_NOW(a_store_locked, res.valid && res.status == ST_GOOD, !rx.ready, "byte input open while frame words are emitted")
  `ISFP_ASSERT_NEXT(a_word_gap, res.valid && res.ready && !res.last, !res.valid, "next word shown before its memory read")

endmodule

// ----- tb/isfp_frame_checker.sv -----
// Checker for the IMU serial frame parser: follows register writes and accepted bytes,
// predicts the frame results and compares them with the results the block hands out.
// Depends on isfp_pkg and the channel interfaces in isfp_if.sv.
module isfp_frame_checker
  import isfp_pkg::*;
#(
  parameter int MaxPayload = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  isfp_byte_if       rx_mon,
  isfp_result_if     res_mon,
  input  logic       end_check,
  output int         mismatches,
  output int         outstanding
);

  localparam logic [2:0] HUNT_FIRST  = 3'd0;
  localparam logic [2:0] HUNT_SECOND = 3'd1;
  localparam logic [2:0] LEN_LO      = 3'd2;
  localparam logic [2:0] LEN_HI      = 3'd3;
  localparam logic [2:0] CHECK_LO    = 3'd4;
  localparam logic [2:0] CHECK_HI    = 3'd5;
  localparam logic [2:0] PAYLOAD     = 3'd6;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic        last;
  } frame_word_t;

  frame_word_t  word_queue[$];
  logic [2:0]   phase;
  logic [7:0]   sync_a, sync_b, tag;
  logic         crc_on;
  logic [15:0]  frame_len, check_expect, byte_cnt, crc_run;
  logic [7:0]   stored[DataLength];
  int           errs;
  bit           closed;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    phase        = HUNT_FIRST;
    frame_len    = '0;
    check_expect = '0;
    byte_cnt     = '0;
    crc_run      = CRC_INIT;
  endfunction

  function automatic void push_word(input logic [1:0] st, input logic [4:0] idx,
                                    input logic [31:0] val, input logic fin);
    word_queue.push_back(frame_word_t'{st, idx, val, fin});
  endfunction

  function automatic void close_frame();
    logic [31:0] val;
    if (crc_on && crc_run != check_expect) begin
      push_word(ST_CRC_ERR, '0, '0, 1'b1);
    end else if (frame_len < DataLength || stored[0] != tag) begin
      push_word(ST_UNSUP, '0, '0, 1'b1);
    end else begin
      for (int w = 0; w < NumWords; w++) begin
        val = {stored[4*w+3], stored[4*w+2], stored[4*w+1], stored[4*w]};
        push_word(ST_GOOD, 5'(w), val, w == NumWords - 1);
      end
    end
    restart_hunt();
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    unique case (phase)
      HUNT_SECOND: begin
        if (b == sync_b) begin
          phase = LEN_LO;
        end else if (b == sync_a) begin
          phase = HUNT_SECOND;
        end else begin
          phase = HUNT_FIRST;
        end
      end
      LEN_LO: begin
        frame_len = {8'h00, b};
        crc_run   = crc16_step(crc16_step(crc16_step(CRC_INIT, sync_a), sync_b), b);
        phase     = LEN_HI;
      end
      LEN_HI: begin
        frame_len[15:8] = b;
        crc_run         = crc16_step(crc_run, b);
        if (frame_len == 0 || frame_len > MaxPayload) begin
          restart_hunt();
          push_word(ST_BAD_LEN, '0, '0, 1'b1);
        end else begin
          phase = CHECK_LO;
        end
      end
      CHECK_LO: begin
        check_expect = {8'h00, b};
        phase        = CHECK_HI;
      end
      CHECK_HI: begin
        check_expect[15:8] = b;
        byte_cnt           = '0;
        phase              = PAYLOAD;
      end
      PAYLOAD: begin
        if (byte_cnt < DataLength) begin
          stored[byte_cnt] = b;
        end
        crc_run  = crc16_step(crc_run, b);
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= frame_len) begin
          close_frame();
        end
      end
      default: begin
        phase = (b == sync_a) ? HUNT_SECOND : HUNT_FIRST;
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      errs++;
    end
  endfunction

  function automatic void compare_result();
    frame_word_t want;
    if (word_queue.size() == 0) begin
      $display("%0t: unexpected result status %0d index %0d value 0x%h last %0b", $time,
               res_mon.status, res_mon.word_index, res_mon.word_value, res_mon.last);
      errs++;
    end else begin
      want = word_queue.pop_front();
      check_field("status", 32'(want.status), 32'(res_mon.status));
      check_field("word_index", 32'(want.word_index), 32'(res_mon.word_index));
      check_field("word_value", want.word_value, res_mon.word_value);
      check_field("last", 32'(want.last), 32'(res_mon.last));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sync_a = 8'h5A;
      sync_b = 8'hA5;
      tag    = 8'h91;
      crc_on = 1'b0;
      restart_hunt();
      word_queue.delete();
      errs   = 0;
      closed = 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYNC_FIRST:  sync_a = cfg_data;
          CFG_SYNC_SECOND: sync_b = cfg_data;
          CFG_DATA_TAG:    tag    = cfg_data;
          CFG_CRC_ENABLE:  crc_on = cfg_data[0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        compare_result();
      end
      if (rx_mon.valid && rx_mon.ready) begin
        take_byte(rx_mon.rx_byte);
      end
      if (end_check && !closed) begin
        closed = 1'b1;
        if (word_queue.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time, word_queue.size());
          errs += word_queue.size();
        end
      end
    end
    mismatches  <= errs;
    outstanding <= word_queue.size();
  end

endmodule

// ----- tb/imu_serial_frame_parser_core_tb.sv -----
// Testbench top for imu_serial_frame_parser_core: drives bytes, register writes and result
// back-pressure with random gaps, and gives the verdict from the checker's failure count.
// Depends on isfp_pkg, isfp_if.sv, the parser RTL and isfp_frame_checker.
module imu_serial_frame_parser_core_tb;
  import isfp_pkg::*;

  localparam int MaxLen        = 512;
  localparam int StallLimit    = 300;
  localparam int SettleCycles  = 20;
  localparam int TargetBytes   = 220;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       end_check;
  int         mismatches;
  int         pending_words;

  bit         no_gaps;
  int         ready_hold;
  int         res_stall;
  int         quiet;
  int         bytes_sent;
  int         results_taken;
  int         settings_used;

  logic [7:0] cur_sync_first  = 8'h5A;
  logic [7:0] cur_sync_second = 8'hA5;
  logic [7:0] cur_tag         = 8'h91;

  isfp_byte_if   rx_ch();
  isfp_result_if res_ch();

  always #5 clk = ~clk;

  imu_serial_frame_parser_core #(
    .MaxPayload(MaxLen)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .res      (res_ch)
  );

  isfp_frame_checker #(
    .MaxPayload(MaxLen)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_mon     (rx_ch),
    .res_mon    (res_ch),
    .end_check  (end_check),
    .mismatches (mismatches),
    .outstanding(pending_words)
  );

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready  <= 1'b0;
      ready_hold    <= 0;
      results_taken <= 0;
    end else if (res_ch.ready) begin
      if (res_ch.valid) begin
        results_taken <= results_taken + 1;
        res_stall = no_gaps ? 0 : $urandom_range(0, 5);
        if (res_stall != 0) begin
          res_ch.ready <= 1'b0;
          ready_hold   <= res_stall - 1;
        end
      end
    end else if (ready_hold == 0) begin
      res_ch.ready <= 1'b1;
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("Timeout: no handshake for %0d cycles at %0t", StallLimit, $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] t,
                          input logic en);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data  <= s1;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data  <= s2;
    @(posedge clk);
    cfg_index <= CFG_DATA_TAG;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= CFG_CRC_ENABLE;
    cfg_data  <= {7'($urandom), en};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sync_first  = s1;
    cur_sync_second = s2;
    cur_tag         = t;
    settings_used++;
  endtask

  task automatic end_phase();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Lengths of zero or above the maximum send only the header.
  task automatic send_frame(input logic [15:0] len, input bit tag_ok, input bit crc_ok,
                            input bit extra_sync);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] chk;
    crc = fold_crc(fold_crc(CRC_INIT, cur_sync_first), cur_sync_second);
    crc = fold_crc(fold_crc(crc, len[7:0]), len[15:8]);
    if (len != 0 && len <= MaxLen) begin
      for (int i = 0; i < len; i++) begin
        if (i == 0) begin
          b = tag_ok ? cur_tag : cur_tag ^ 8'($urandom_range(1, 255));
        end else begin
          b = 8'($urandom);
        end
        body.push_back(b);
        crc = fold_crc(crc, b);
      end
    end
    chk = crc_ok ? crc : crc ^ 16'($urandom_range(1, 65535));
    if (extra_sync) begin
      send_byte(cur_sync_first);
    end
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len != 0 && len <= MaxLen) begin
      send_byte(chk[7:0]);
      send_byte(chk[15:8]);
      foreach (body[i]) send_byte(body[i]);
    end
  endtask

  task automatic random_frame();
    logic [7:0] b;
    bit         extra;
    int         n;
    no_gaps <= ($urandom_range(0, 3) == 0);
    extra = (cur_sync_first != cur_sync_second) && ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 8))
      0, 1, 2: begin
        send_frame(($urandom_range(0, 2) == 0) ? 16'd76 : 16'($urandom_range(77, 96)),
                   1'b1, 1'b1, extra);
      end
      3: send_frame(16'($urandom_range(76, 84)), 1'b0, 1'b1, extra);
      4: send_frame(16'($urandom_range(1, 84)), 1'b1, 1'b0, extra);
      5: begin
        send_frame(($urandom_range(0, 3) == 0) ? 16'd75 : 16'($urandom_range(1, 10)),
                   1'($urandom_range(0, 1)), 1'b1, extra);
      end
      6: begin
        send_frame($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(MaxLen + 1, 65535)),
                   1'b1, 1'b1, extra);
      end
      7: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          do b = 8'($urandom); while (b == cur_sync_first);
          send_byte(b);
        end
      end
      default: begin
        send_byte(cur_sync_first);
        do b = 8'($urandom); while (b == cur_sync_first || b == cur_sync_second);
        send_byte(b);
      end
    endcase
  endtask

  initial begin
    int         ph;
    int         start;
    logic [7:0] a;
    logic [7:0] c;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SYNC_FIRST;
    cfg_data      = 8'h00;
    end_check     = 1'b0;
    no_gaps       = 1'b0;
    bytes_sent    = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: repeated first sync byte, then bad and extreme lengths.
    send_frame(16'd0, 1'b1, 1'b1, 1'b1);
    send_frame(16'd513, 1'b1, 1'b1, 1'b0);
    send_frame(16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_byte(cur_sync_first);
    send_byte(8'h00);
    end_phase();

    // CRC checking on: a short frame with a good CRC, then one with a bad CRC.
    set_regs(8'h5A, 8'hA5, 8'h91, 1'b1);
    send_frame(16'd1, 1'b1, 1'b1, 1'b0);
    send_frame(16'd1, 1'b1, 1'b0, 1'b0);
    end_phase();

    ph = 0;
    while (bytes_sent < TargetBytes) begin
      case (ph % 4)
        0: set_regs(8'h00, 8'hFF, 8'h00, 1'b1);
        1: set_regs(8'hFF, 8'h00, 8'hFF, 1'b0);
        default: begin
          a = 8'($urandom);
          do c = 8'($urandom); while (c == a);
          set_regs(a, c, 8'($urandom), 1'($urandom_range(0, 1)));
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 50 && bytes_sent < TargetBytes) random_frame();
      end_phase();
      ph++;
    end

    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("Sent %0d bytes under %0d register settings and took %0d results.",
             bytes_sent, settings_used, results_taken);
    $display("Frames covered good data, CRC errors, bad lengths, short and mistagged frames.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/isfp_pkg.sv
src/isfp_if.sv
src/isfp_front.sv
src/isfp_job_queue.sv
src/isfp_back.sv
src/imu_serial_frame_parser_core.sv
tb/isfp_frame_checker.sv
tb/imu_serial_frame_parser_core_tb.sv
